### design/ltt_pkg.sv
// shared types and constants of the 3x3 local threshold block
package ltt_pkg;

  localparam int unsigned PIX_W    = 8;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned WIDTH_W  = 11;
  localparam int unsigned HEIGHT_W = 16;
  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned IDX_W    = 2;
  localparam int unsigned ROW_W    = 17;
  localparam int unsigned LINE_W   = 2 * PIX_W;

  // rows beyond this behave alike for every height
  localparam logic [ROW_W-1:0] ROW_SAT = 17'd65537;

  localparam logic [MODE_W-1:0]   MODE_RST   = 2'd0;
  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 16'd480;
  localparam logic [LEVEL_W-1:0]  LEVEL_RST  = 8'd110;

  localparam logic [PIX_W-1:0] BLACK = 8'd0;
  localparam logic [PIX_W-1:0] WHITE = 8'd255;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_GAUSS  = 2'd0,
    MODE_MEAN   = 2'd1,
    MODE_GLOBAL = 2'd2
  } mode_e;

  typedef enum logic [IDX_W-1:0] {
    REG_MODE   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2,
    REG_LEVEL  = 2'd3
  } reg_e;

  // position of one transaction in the frame
  typedef struct packed {
    logic emit;
    logic last;
    logic first;
    logic mid_ok;
    logic top_ok;
  } ltt_pos_t;

  typedef logic [2:0][PIX_W-1:0] ltt_col_t;

endpackage

### design/local_threshold_3x3_top.sv
// top level of the streaming 3x3 local threshold block
// Grey pixels enter in raster order, up to one transaction per clock, and each gives one
// binary pixel (0 or 255) width+1 transactions later, when the pixel right of and
// below it has arrived; after the last pixel of a frame, width+1 drain transactions
// flush the remaining results and the result of the last pixel carries frame_end.
// The line store read is issued as a transaction is accepted; in the next cycle the
// window and decision stage uses that read and loads the result register when
// the output can take it; with the output not stalled, the sustained rate is one
// transaction per clock. While a result is blocked, one more transaction can
// wait in the window stage before the input stalls. The two line stores share
// one ram of MAX_WIDTH words of 16 bits. Configuration takes effect at once;
// the input is stalled for the cycle after each register write and for the
// first cycle after reset while the frame size product settles.
module local_threshold_3x3_top #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ltt_pkg::IDX_W-1:0]     cfg_index_i,
  input  logic [ltt_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          operation_i,
  input  logic [ltt_pkg::PIX_W-1:0]     pixel_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ltt_pkg::PIX_W-1:0]     binary_pixel_o,
  output logic                          frame_end_o
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);

  logic [ltt_pkg::MODE_W-1:0]   mode_q;
  logic [ltt_pkg::WIDTH_W-1:0]  width_q;
  logic [ltt_pkg::HEIGHT_W-1:0] height_q;
  logic [ltt_pkg::LEVEL_W-1:0]  level_q;
  logic                         cfg_wait_q;

  logic                        in_accept;
  logic                        s1_free;
  logic [AW-1:0]               rd_addr;
  ltt_pkg::ltt_pos_t           pos;
  logic [ltt_pkg::PIX_W-1:0]   bot;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [ltt_pkg::LINE_W-1:0]  ram_wdata;
  logic [ltt_pkg::LINE_W-1:0]  ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= ltt_pkg::MODE_RST;
      width_q    <= ltt_pkg::WIDTH_RST;
      height_q   <= ltt_pkg::HEIGHT_RST;
      level_q    <= ltt_pkg::LEVEL_RST;
      cfg_wait_q <= 1'b1;
    end else begin
      cfg_wait_q <= cfg_we_i;
      if (cfg_we_i) begin
        unique case (ltt_pkg::reg_e'(cfg_index_i))
          ltt_pkg::REG_MODE:   mode_q   <= cfg_data_i[ltt_pkg::MODE_W-1:0];
          ltt_pkg::REG_WIDTH:  width_q  <= cfg_data_i[ltt_pkg::WIDTH_W-1:0];
          ltt_pkg::REG_HEIGHT: height_q <= cfg_data_i[ltt_pkg::HEIGHT_W-1:0];
          ltt_pkg::REG_LEVEL:  level_q  <= cfg_data_i[ltt_pkg::LEVEL_W-1:0];
          default:             mode_q   <= mode_q;
        endcase
      end
    end
  end

  assign in_stall_o = cfg_wait_q || !s1_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  ltt_ctrl #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_accept),
    .operation_i(operation_i),
    .pixel_i    (pixel_i),
    .width_i    (width_q),
    .height_i   (height_q),
    .addr_o     (rd_addr),
    .pos_o      (pos),
    .bot_o      (bot)
  );

  ltt_ram #(
    .WIDTH(ltt_pkg::LINE_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (in_accept),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  ltt_window #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_window (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (in_accept),
    .addr_i        (rd_addr),
    .pos_i         (pos),
    .bot_i         (bot),
    .mode_i        (mode_q),
    .level_i       (level_q),
    .rdata_i       (ram_rdata),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .free_o        (s1_free),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .binary_pixel_o(binary_pixel_o),
    .frame_end_o   (frame_end_o)
  );

endmodule

### design/ltt_ram.sv
// generic single write port ram with registered read
module ltt_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/ltt_ctrl.sv
// raster position tracking, frame end detection and line store addressing
module ltt_ctrl #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  accept_i,
  input  logic                                  operation_i,
  input  logic [ltt_pkg::PIX_W-1:0]             pixel_i,
  input  logic [ltt_pkg::WIDTH_W-1:0]           width_i,
  input  logic [ltt_pkg::HEIGHT_W-1:0]          height_i,
  output logic [$clog2(MAX_WIDTH)-1:0]          addr_o,
  output ltt_pkg::ltt_pos_t                     pos_o,
  output logic [ltt_pkg::PIX_W-1:0]             bot_o
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CW = WW + ltt_pkg::HEIGHT_W;
  localparam int unsigned RW = ltt_pkg::ROW_W;

  logic [WW-1:0] w_eff;
  logic [ltt_pkg::HEIGHT_W-1:0] h_eff;
  logic [RW-1:0] h_ext;
  logic [CW-1:0] total_d, total_q;
  logic [WW-1:0] col_d, col_q;
  logic [RW-1:0] row_d, row_q;
  logic [CW-1:0] cnt_d, cnt_q;
  logic          wrap;
  logic [WW-1:0] c;
  logic [RW-1:0] r;
  logic          bot_ok;
  logic [CW:0]   cnt_inc;
  ltt_pkg::ltt_pos_t pos;

  always_comb begin
    if (width_i == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_i) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_i);
    end
    h_eff   = (height_i == '0) ? ltt_pkg::HEIGHT_W'(1) : height_i;
    h_ext   = RW'(h_eff);
    total_d = CW'(w_eff) * CW'(h_eff);
  end

  always_comb begin
    wrap = (col_q >= w_eff);
    c    = wrap ? '0 : col_q;
    if (wrap && (row_q != ltt_pkg::ROW_SAT)) begin
      r = row_q + RW'(1);
    end else begin
      r = row_q;
    end
    bot_ok     = (r < h_ext);
    pos.mid_ok = (r >= RW'(1)) && ((r - RW'(1)) < h_ext);
    pos.top_ok = (r >= RW'(2)) && ((r - RW'(2)) < h_ext);
    pos.first  = (c == '0);
    pos.emit   = pos.first ? (r >= RW'(2)) : (r >= RW'(1));
    cnt_inc    = {1'b0, cnt_q} + (CW + 1)'(1);
    pos.last   = pos.emit && (cnt_inc >= {1'b0, total_q});

    if (pos.last) begin
      col_d = '0;
      row_d = '0;
      cnt_d = '0;
    end else begin
      col_d = c + WW'(1);
      row_d = r;
      cnt_d = pos.emit ? cnt_inc[CW-1:0] : cnt_q;
    end
  end

  // product of the clamped sizes, refreshed every cycle, and the raster position, advanced on accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      col_q   <= '0;
      row_q   <= '0;
      cnt_q   <= '0;
    end else begin
      total_q <= total_d;
      if (accept_i) begin
        col_q <= col_d;
        row_q <= row_d;
        cnt_q <= cnt_d;
      end
    end
  end

  assign addr_o = c[AW-1:0];
  assign pos_o  = pos;
  assign bot_o  = ((operation_i == ltt_pkg::OP_DRAIN) || !bot_ok) ? '0 : pixel_i;

  a_row_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= ltt_pkg::ROW_SAT)
    else $error("row index beyond saturation");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && pos.last |=> (col_q == '0) && (row_q == '0) && (cnt_q == '0))
    else $error("position not cleared after frame end");

endmodule

### design/ltt_window.sv
// line store read-back, 3x3 window, threshold decision and result register
module ltt_window #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              load_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]      addr_i,
  input  ltt_pkg::ltt_pos_t                 pos_i,
  input  logic [ltt_pkg::PIX_W-1:0]         bot_i,
  input  logic [ltt_pkg::MODE_W-1:0]        mode_i,
  input  logic [ltt_pkg::LEVEL_W-1:0]       level_i,
  input  logic [ltt_pkg::LINE_W-1:0]        rdata_i,
  output logic                              ram_we_o,
  output logic [$clog2(MAX_WIDTH)-1:0]      ram_waddr_o,
  output logic [ltt_pkg::LINE_W-1:0]        ram_wdata_o,
  output logic                              free_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [ltt_pkg::PIX_W-1:0]         binary_pixel_o,
  output logic                              frame_end_o
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned PW = ltt_pkg::PIX_W;

  logic                        s1_valid_q;
  logic [AW-1:0]               s1_addr_q;
  ltt_pkg::ltt_pos_t           s1_pos_q;
  logic [PW-1:0]               s1_bot_q;
  logic                        fwd_hit_q;
  logic [ltt_pkg::LINE_W-1:0]  fwd_data_q;

  ltt_pkg::ltt_col_t lft_q, ctr_q, rgt_q;
  ltt_pkg::ltt_col_t new_col, right;

  logic                        out_valid_q;
  logic [PW-1:0]               out_pix_q;
  logic                        out_last_q;

  logic                        out_en;
  logic                        s1_go;
  logic [ltt_pkg::LINE_W-1:0]  line;
  logic [PW-1:0]               up_raw, md_raw;
  logic [PW-1:0]               x;
  logic [PW:0]                 gsum;
  logic [11:0]                 msum;
  logic [11:0]                 mthr;
  logic                        black;

  assign out_en = !out_valid_q || !out_stall_i;
  assign s1_go  = s1_valid_q && (!s1_pos_q.emit || out_en);
  assign free_o = !s1_valid_q || s1_go;

  // bypass for a read that met a write to the same column
  assign line   = fwd_hit_q ? fwd_data_q : rdata_i;
  assign up_raw = line[ltt_pkg::LINE_W-1:PW];
  assign md_raw = line[PW-1:0];

  assign ram_we_o    = s1_go;
  assign ram_waddr_o = s1_addr_q;
  assign ram_wdata_o = {md_raw, s1_bot_q};

  always_comb begin
    new_col[0] = s1_pos_q.top_ok ? up_raw : '0;
    new_col[1] = s1_pos_q.mid_ok ? md_raw : '0;
    new_col[2] = s1_bot_q;
    right      = s1_pos_q.first ? '0 : new_col;
    x          = rgt_q[1];

    gsum = (PW + 1)'(x >> 2)
         + (PW + 1)'(rgt_q[0] >> 3) + (PW + 1)'(rgt_q[2] >> 3)
         + (PW + 1)'(ctr_q[1] >> 3) + (PW + 1)'(right[1] >> 3)
         + (PW + 1)'(ctr_q[0] >> 4) + (PW + 1)'(right[0] >> 4)
         + (PW + 1)'(ctr_q[2] >> 4) + (PW + 1)'(right[2] >> 4);

    msum = 12'(ctr_q[0]) + 12'(ctr_q[1]) + 12'(ctr_q[2])
         + 12'(rgt_q[0]) + 12'(rgt_q[1]) + 12'(rgt_q[2])
         + 12'(right[0]) + 12'(right[1]) + 12'(right[2]);
    // x at least the floored mean when the sum stays below nine times x plus nine
    mthr = 12'({x, 3'b000}) + 12'(x) + 12'd9;

    unique case (mode_i)
      ltt_pkg::MODE_GAUSS: black = ((PW + 1)'(x) > gsum);
      ltt_pkg::MODE_MEAN:  black = (msum < mthr);
      default:             black = (x < level_i);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_hit_q   <= 1'b0;
      out_valid_q <= 1'b0;
      lft_q       <= '0;
      ctr_q       <= '0;
      rgt_q       <= '0;
    end else begin
      if (load_i) begin
        s1_valid_q <= 1'b1;
        fwd_hit_q  <= s1_go && (s1_addr_q == addr_i);
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end

      if (s1_go) begin
        if (s1_pos_q.last) begin
          lft_q <= '0;
          ctr_q <= '0;
          rgt_q <= '0;
        end else if (s1_pos_q.first) begin
          lft_q <= '0;
          ctr_q <= '0;
          rgt_q <= new_col;
        end else begin
          lft_q <= ctr_q;
          ctr_q <= rgt_q;
          rgt_q <= new_col;
        end
      end

      if (s1_go && s1_pos_q.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s1_addr_q  <= addr_i;
      s1_pos_q   <= pos_i;
      s1_bot_q   <= bot_i;
      fwd_data_q <= {md_raw, s1_bot_q};
    end
    if (s1_go && s1_pos_q.emit) begin
      out_pix_q  <= black ? ltt_pkg::BLACK : ltt_pkg::WHITE;
      out_last_q <= s1_pos_q.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign binary_pixel_o = out_pix_q;
  assign frame_end_o    = out_last_q;

  a_binary_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_pix_q == ltt_pkg::BLACK) || (out_pix_q == ltt_pkg::WHITE))
    else $error("result neither black nor white");

  a_window_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && s1_pos_q.last |=> (lft_q == '0) && (ctr_q == '0) && (rgt_q == '0))
    else $error("window not cleared after frame end");

  a_stage_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_pos_q.emit && out_valid_q && out_stall_i
      |=> s1_valid_q && $stable(s1_addr_q))
    else $error("window stage moved while result blocked");

endmodule
